// File: rtl/core/bmt_pkg.sv
// Shared types and constants for the breakpoint match table.
package bmt_pkg;

   localparam int MAX_ENTRIES_DEFAULT = 16;
   localparam int ADDR_W   = 32;
   localparam int LEN_W    = 8;
   localparam int SLOT_W   = 4;
   localparam int OP_W     = 4;
   localparam int HIDX_W   = 4;
   localparam int COUNT_W  = 5;
   localparam int STATUS_W = 2;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 56;

   typedef enum logic [OP_W-1:0] {
      OP_FIND_CODE   = 4'd0,
      OP_ADD_CODE    = 4'd1,
      OP_REMOVE_CODE = 4'd2,
      OP_FIND_DATA   = 4'd3,
      OP_ADD_DATA    = 4'd4,
      OP_REMOVE_DATA = 4'd5,
      OP_REMOVE_IDX  = 4'd6,
      OP_CLEAR       = 4'd7,
      OP_READ        = 4'd8
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_DONE = 2'd0,
      STS_DUP  = 2'd1,
      STS_FULL = 2'd2,
      STS_MISS = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_MATCH,
      S_APPLY
   } state_type;

   typedef struct packed {
      logic              is_data;
      logic [ADDR_W-1:0] address;
      logic [LEN_W-1:0]  length;
   } entry_type;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [ADDR_W-1:0] address;
      logic [LEN_W-1:0]  length;
      logic [SLOT_W-1:0] slot;
   } request_type;

   typedef struct packed {
      logic compare;
      logic indexed;
      logic is_data;
      logic load;
      logic shift;
   } cell_ctl_type;

endpackage

// File: rtl/core/bmt_cell.sv
// One table slot: holds an entry, compares it against the request, shifts from its neighbor.
module bmt_cell #(
   parameter int POS   = 0,
   parameter int CNT_W = 5
) (
   input  logic                 clock,
   input  logic                 reset,
   input  bmt_pkg::cell_ctl_type ctl,
   input  bmt_pkg::request_type  req,
   input  logic [CNT_W-1:0]     count,
   input  bmt_pkg::entry_type    neighbor,
   output bmt_pkg::entry_type    entry,
   output logic                 match
);
   import bmt_pkg::*;

   localparam logic [6:0] POS_V = 7'(POS);

   entry_type entry_ff, entry_in;
   entry_type new_entry;
   logic      match_ff, match_in;
   logic      valid;
   logic      key_hit;

   always_comb begin
      new_entry.is_data = ctl.is_data;
      new_entry.address = req.address;
      new_entry.length  = ctl.is_data ? req.length : '0;
      if (ctl.load) begin
         entry_in = new_entry;
      end else if (ctl.shift) begin
         entry_in = neighbor;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_comb begin
      valid   = POS_V < 7'(count);
      key_hit = (entry_ff.address == req.address) &&
                (ctl.is_data ? (entry_ff.is_data && entry_ff.length == req.length)
                             : !entry_ff.is_data);
      if (ctl.compare) begin
         match_in = valid && (ctl.indexed ? (POS_V == 7'(req.slot)) : key_hit);
      end else begin
         match_in = match_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
      end else begin
         match_ff <= match_in;
      end
   end

   assign entry = entry_ff;
   assign match = match_ff;

endmodule

// File: rtl/core/breakpoint_match_table.sv
// Breakpoint match table: ordered code/data breakpoint table built as a row of slot cells.
// A request goes through the compare stage in every cell (S_MATCH), then the first-match
//   resolve and table update stage (S_APPLY), which waits while the output register is full,
//   before rsp_tvalid rises. A new request is taken only in S_IDLE, after the last leaves S_APPLY.
// A finished response waits in the output register while the next request is taken.
// Reset clears the entry count, the state machine and the response valid; entry storage
//   is not cleared and is only read below the count.
module breakpoint_match_table #(
   parameter int MAX_ENTRIES = bmt_pkg::MAX_ENTRIES_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // [31:0] address, [39:32] data_length, [43:40] slot_index, [47:44] zero
   input  logic [bmt_pkg::REQ_DATA_W-1:0] req_tdata,
   // [3:0] req_type
   input  logic [bmt_pkg::OP_W-1:0]       req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [0] hit, [4:1] hit_index, [36:5] entry_address, [44:37] entry_length,
   // [49:45] entry_count, [51:50] status, [55:52] zero
   output logic [bmt_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // [0] entry_is_data
   output logic                           rsp_tuser
);
   import bmt_pkg::*;

   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

   state_type   state_ff, state_in;
   request_type req_ff, req_in;
   logic [CNT_W-1:0] count_ff, count_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_hit_ff, rsp_hit_in;
   logic [HIDX_W-1:0]  rsp_index_ff, rsp_index_in;
   entry_type          rsp_entry_ff, rsp_entry_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   status_type         rsp_status_ff, rsp_status_in;

   logic take_req;
   logic do_compare;
   logic commit;
   logic out_free;

   logic op_is_data;
   logic op_indexed;

   entry_type        cell_entry [MAX_ENTRIES];
   cell_ctl_type     cell_ctl   [MAX_ENTRIES];
   logic [MAX_ENTRIES-1:0] match_vec;
   logic [MAX_ENTRIES-1:0] low_vec;
   logic [MAX_ENTRIES-1:0] first_vec;
   logic [MAX_ENTRIES-1:0] ge_vec;
   logic [MAX_ENTRIES-1:0] shift_vec;
   logic                   any_match;
   logic [IDX_W-1:0]       first_idx;
   entry_type              first_entry;
   entry_type              new_entry;
   logic                   full;
   logic                   add_new;

   assign out_free = !rsp_valid_ff || rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) state_in = S_MATCH;
         end
         S_MATCH: begin
            state_in = S_APPLY;
         end
         S_APPLY: begin
            if (out_free) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state outputs
   always_comb begin
      req_tready = 1'b0;
      do_compare = 1'b0;
      commit     = 1'b0;
      case (state_ff)
         S_IDLE:  req_tready = 1'b1;
         S_MATCH: do_compare = 1'b1;
         S_APPLY: commit     = out_free;
         default: req_tready = 1'b0;
      endcase
   end

   assign take_req = req_tvalid && req_tready;

   always_comb begin
      req_in = req_ff;
      if (take_req) begin
         req_in.op      = req_tuser;
         req_in.address = req_tdata[ADDR_W-1:0];
         req_in.length  = req_tdata[ADDR_W +: LEN_W];
         req_in.slot    = req_tdata[ADDR_W+LEN_W +: SLOT_W];
      end
   end

   always_comb begin
      op_is_data = (req_ff.op == OP_FIND_DATA) || (req_ff.op == OP_ADD_DATA) ||
                   (req_ff.op == OP_REMOVE_DATA);
      op_indexed = (req_ff.op == OP_REMOVE_IDX) || (req_ff.op == OP_READ);
   end

   // first match, slots at or above it, and the matched entry
   always_comb begin
      any_match   = |match_vec;
      low_vec     = match_vec ^ (match_vec - MAX_ENTRIES'(1));
      first_vec   = low_vec & match_vec;
      ge_vec      = ~low_vec | first_vec;
      first_idx   = '0;
      first_entry = '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         if (first_vec[i]) begin
            first_idx   = first_idx | IDX_W'(i);
            first_entry = first_entry | cell_entry[i];
         end
      end
   end

   always_comb begin
      new_entry.is_data = op_is_data;
      new_entry.address = req_ff.address;
      new_entry.length  = op_is_data ? req_ff.length : '0;
      full = count_ff == CNT_W'(MAX_ENTRIES);
   end

   // resolve the request
   always_comb begin
      count_in      = count_ff;
      add_new       = 1'b0;
      shift_vec     = '0;
      rsp_hit_in    = 1'b0;
      rsp_index_in  = HIDX_W'(first_idx);
      rsp_entry_in  = first_entry;
      rsp_status_in = STS_DONE;
      case (req_ff.op)
         OP_FIND_CODE, OP_FIND_DATA, OP_READ: begin
            rsp_hit_in    = any_match;
            rsp_status_in = any_match ? STS_DONE : STS_MISS;
         end
         OP_ADD_CODE, OP_ADD_DATA: begin
            if (any_match) begin
               rsp_hit_in    = 1'b1;
               rsp_status_in = STS_DUP;
            end else if (full) begin
               rsp_status_in = STS_FULL;
            end else begin
               add_new      = 1'b1;
               rsp_hit_in   = 1'b1;
               rsp_index_in = HIDX_W'(count_ff);
               rsp_entry_in = new_entry;
               count_in     = count_ff + CNT_W'(1);
            end
         end
         OP_REMOVE_CODE, OP_REMOVE_DATA, OP_REMOVE_IDX: begin
            if (any_match) begin
               rsp_hit_in = 1'b1;
               shift_vec  = ge_vec;
               count_in   = count_ff - CNT_W'(1);
            end else begin
               rsp_status_in = STS_MISS;
            end
         end
         OP_CLEAR: begin
            count_in = '0;
         end
         default: begin
            rsp_status_in = STS_MISS;
         end
      endcase
      if (!rsp_hit_in) begin
         rsp_index_in = '0;
         rsp_entry_in = '0;
      end
      rsp_count_in = COUNT_W'(count_in);
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   genvar g;
   generate
      for (g = 0; g < MAX_ENTRIES; g++) begin : g_cell
         entry_type next_entry;
         if (g < MAX_ENTRIES - 1) begin : g_mid
            assign next_entry = cell_entry[g+1];
         end else begin : g_end
            assign next_entry = cell_entry[g];
         end

         always_comb begin
            cell_ctl[g].compare = do_compare;
            cell_ctl[g].indexed = op_indexed;
            cell_ctl[g].is_data = op_is_data;
            cell_ctl[g].load    = commit && add_new && (count_ff == CNT_W'(g));
            cell_ctl[g].shift   = commit && shift_vec[g];
         end

         bmt_cell #(
            .POS   (g),
            .CNT_W (CNT_W)
         ) u_cell (
            .clock    (clock),
            .reset    (reset),
            .ctl      (cell_ctl[g]),
            .req      (req_ff),
            .count    (count_ff),
            .neighbor (next_entry),
            .entry    (cell_entry[g]),
            .match    (match_vec[g])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= commit ? count_in : count_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      if (commit) begin
         rsp_hit_ff    <= rsp_hit_in;
         rsp_index_ff  <= rsp_index_in;
         rsp_entry_ff  <= rsp_entry_in;
         rsp_count_ff  <= rsp_count_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_entry_ff.is_data;
   assign rsp_tdata  = {4'b0, rsp_status_ff, rsp_count_ff, rsp_entry_ff.length,
                        rsp_entry_ff.address, rsp_index_ff, rsp_hit_ff};

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_ENTRIES))
      else $error("entry count above table size");

   a_first_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(first_vec))
      else $error("more than one first match");

   a_accept_to_match: assert property (@(posedge clock) disable iff (reset)
      take_req |=> state_ff == S_MATCH)
      else $error("request accepted without compare stage");

   a_count_only_on_commit: assert property (@(posedge clock) disable iff (reset)
      !$stable(count_ff) |-> $past(commit))
      else $error("entry count changed outside update stage");

   a_hit_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_hit_ff) |-> (rsp_status_ff == STS_DONE || rsp_status_ff == STS_DUP))
      else $error("reported entry with failing status");
`endif

endmodule

// File: tb/tb.sv
// Self-checking stream testbench for the breakpoint match table.
module tb;
   import bmt_pkg::*;

   localparam int TABLE_DEPTH    = MAX_ENTRIES_DEFAULT;
   localparam int RANDOM_ITEMS   = 1100;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_AT_RSP    = 200;
   localparam int HOLD_CYCLES    = 150;

   typedef struct packed {
      logic              hit;
      logic [HIDX_W-1:0] hit_index;
      logic              is_data;
      logic [ADDR_W-1:0] address;
      logic [LEN_W-1:0]  length;
      logic [COUNT_W-1:0] count;
      logic [STATUS_W-1:0] status;
   } rsp_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [OP_W-1:0]       req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;

   breakpoint_match_table u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // shadow breakpoint table
   logic [ADDR_W-1:0] tbl_addr [TABLE_DEPTH];
   logic              tbl_is_data [TABLE_DEPTH];
   logic [LEN_W-1:0]  tbl_len [TABLE_DEPTH];
   int                tbl_count = 0;

   request_type  pending_req[$];
   rsp_item_type due_rsp[$];
   request_type  cur_req;

   int  req_accepted = 0;
   int  rsp_accepted = 0;
   int  calm_mark = 0;
   int  mismatches = 0;
   int  tx_gap = 0;
   int  rx_gap = 0;
   int  idle_cycles = 0;
   logic hold_done = 1'b0;
   logic calm;

   assign calm = (req_accepted >= calm_mark);

   function automatic int find_entry(logic is_data, logic [ADDR_W-1:0] a, logic [LEN_W-1:0] l);
      for (int i = 0; i < tbl_count; i++) begin
         if (tbl_addr[i] == a && tbl_is_data[i] == is_data && (!is_data || tbl_len[i] == l))
            return i;
      end
      return TABLE_DEPTH;
   endfunction

   function automatic rsp_item_type report_entry(rsp_item_type r, int i);
      r.hit       = 1'b1;
      r.hit_index = i[HIDX_W-1:0];
      r.is_data   = tbl_is_data[i];
      r.address   = tbl_addr[i];
      r.length    = tbl_len[i];
      return r;
   endfunction

   // compacts later entries down one place
   function automatic void drop_entry(int idx);
      for (int i = idx; i + 1 < tbl_count; i++) begin
         tbl_addr[i]    = tbl_addr[i + 1];
         tbl_is_data[i] = tbl_is_data[i + 1];
         tbl_len[i]     = tbl_len[i + 1];
      end
      tbl_count--;
   endfunction

   function automatic rsp_item_type apply_to_table(request_type rq);
      rsp_item_type r;
      int      pos;
      logic    is_data;
      r = '0;
      is_data = (rq.op == OP_FIND_DATA) || (rq.op == OP_ADD_DATA) || (rq.op == OP_REMOVE_DATA);
      case (rq.op)
         OP_FIND_CODE, OP_FIND_DATA: begin
            pos = find_entry(is_data, rq.address, rq.length);
            if (pos < TABLE_DEPTH) r = report_entry(r, pos);
            else r.status = STS_MISS;
         end
         OP_ADD_CODE, OP_ADD_DATA: begin
            pos = find_entry(is_data, rq.address, rq.length);
            if (pos < TABLE_DEPTH) begin
               r = report_entry(r, pos);
               r.status = STS_DUP;
            end else if (tbl_count >= TABLE_DEPTH) begin
               r.status = STS_FULL;
            end else begin
               tbl_addr[tbl_count]    = rq.address;
               tbl_is_data[tbl_count] = is_data;
               tbl_len[tbl_count]     = is_data ? rq.length : '0;
               tbl_count++;
               r = report_entry(r, tbl_count - 1);
            end
         end
         OP_REMOVE_CODE, OP_REMOVE_DATA: begin
            pos = find_entry(is_data, rq.address, rq.length);
            if (pos < TABLE_DEPTH) begin
               r = report_entry(r, pos);
               drop_entry(pos);
            end else begin
               r.status = STS_MISS;
            end
         end
         OP_REMOVE_IDX: begin
            if (rq.slot < tbl_count) begin
               r = report_entry(r, rq.slot);
               drop_entry(rq.slot);
            end else begin
               r.status = STS_MISS;
            end
         end
         OP_CLEAR: begin
            tbl_count = 0;
         end
         OP_READ: begin
            if (rq.slot < tbl_count) r = report_entry(r, rq.slot);
            else r.status = STS_MISS;
         end
         default: begin
            r.status = STS_MISS;
         end
      endcase
      r.count = tbl_count[COUNT_W-1:0];
      return r;
   endfunction

   function automatic request_type make_req(logic [OP_W-1:0] op, logic [ADDR_W-1:0] a,
                                            logic [LEN_W-1:0] l, logic [SLOT_W-1:0] s);
      request_type rq;
      rq.op      = op;
      rq.address = a;
      rq.length  = l;
      rq.slot    = s;
      return rq;
   endfunction

   always @(posedge clock) begin : drive_req
      request_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
         tx_gap     <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            due_rsp.push_back(apply_to_table(cur_req));
            req_accepted <= req_accepted + 1;
         end
         if (!req_tvalid || req_tready) begin
            if (tx_gap > 0) begin
               tx_gap     <= tx_gap - 1;
               req_tvalid <= 1'b0;
            end else if (pending_req.size() > 0) begin
               nxt = pending_req.pop_front();
               cur_req    <= nxt;
               req_tvalid <= 1'b1;
               req_tdata  <= {4'b0000, nxt.slot, nxt.length, nxt.address};
               req_tuser  <= nxt.op;
               if (!calm && $urandom_range(0, 5) == 0) tx_gap <= $urandom_range(1, 11);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // long hold once, so the request side backs up
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rx_gap     <= 0;
         hold_done  <= 1'b0;
      end else if (!hold_done && rsp_accepted >= HOLD_AT_RSP) begin
         rsp_tready <= 1'b0;
         rx_gap     <= HOLD_CYCLES;
         hold_done  <= 1'b1;
      end else if (rx_gap > 0) begin
         rsp_tready <= 1'b0;
         rx_gap     <= rx_gap - 1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         rsp_tready <= 1'b0;
         rx_gap     <= $urandom_range(0, 10);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_rsp
      rsp_item_type got;
      rsp_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.hit       = rsp_tdata[0];
         got.hit_index = rsp_tdata[4:1];
         got.address   = rsp_tdata[36:5];
         got.length    = rsp_tdata[44:37];
         got.count     = rsp_tdata[49:45];
         got.status    = rsp_tdata[51:50];
         got.is_data   = rsp_tuser;
         rsp_accepted <= rsp_accepted + 1;
         if (due_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"unexpected response: hit=%0d idx=%0d data=%0d addr=%h",
                         " len=%0d cnt=%0d st=%0d"},
                        got.hit, got.hit_index, got.is_data, got.address, got.length,
                        got.count, got.status);
         end else begin
            want = due_rsp.pop_front();
            if (got.hit !== want.hit || got.hit_index !== want.hit_index ||
                got.is_data !== want.is_data || got.address !== want.address ||
                got.length !== want.length || got.count !== want.count ||
                got.status !== want.status) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("response %0d mismatch", rsp_accepted);
                  $display("  want hit=%0d idx=%0d data=%0d addr=%h len=%0d cnt=%0d st=%0d",
                           want.hit, want.hit_index, want.is_data, want.address, want.length,
                           want.count, want.status);
                  $display("  got  hit=%0d idx=%0d data=%0d addr=%h len=%0d cnt=%0d st=%0d",
                           got.hit, got.hit_index, got.is_data, got.address, got.length,
                           got.count, got.status);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("breakpoint_match_table regression: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      logic [ADDR_W-1:0] addr_pool [24];
      logic [LEN_W-1:0]  len_pool [3];
      int pool_n;
      int phase_n;
      int made;
      int pick;
      logic [OP_W-1:0]   op;
      logic [ADDR_W-1:0] a;
      logic [LEN_W-1:0]  l;

      // directed: empty table, extremes, duplicates, kinds, compaction, unused codes
      pending_req.push_back(make_req(OP_FIND_CODE,   32'h0000_0000, 8'h00, 4'd0));
      pending_req.push_back(make_req(OP_READ,        32'h0000_0000, 8'h00, 4'd0));
      pending_req.push_back(make_req(OP_REMOVE_IDX,  32'hFFFF_FFFF, 8'hFF, 4'd15));
      pending_req.push_back(make_req(OP_ADD_CODE,    32'h0000_0000, 8'h00, 4'd0));
      pending_req.push_back(make_req(OP_ADD_CODE,    32'hFFFF_FFFF, 8'hFF, 4'd15));
      pending_req.push_back(make_req(OP_ADD_CODE,    32'h0000_0000, 8'h7E, 4'd3));
      pending_req.push_back(make_req(OP_ADD_DATA,    32'h0000_0000, 8'h00, 4'd0));
      pending_req.push_back(make_req(OP_ADD_DATA,    32'hFFFF_FFFF, 8'hFF, 4'd0));
      pending_req.push_back(make_req(OP_ADD_DATA,    32'hFFFF_FFFF, 8'hFF, 4'd9));
      pending_req.push_back(make_req(OP_FIND_DATA,   32'hFFFF_FFFF, 8'hFE, 4'd0));
      pending_req.push_back(make_req(OP_FIND_DATA,   32'hFFFF_FFFF, 8'hFF, 4'd0));
      pending_req.push_back(make_req(OP_FIND_CODE,   32'hFFFF_FFFF, 8'h11, 4'd0));
      pending_req.push_back(make_req(OP_READ,        32'h0000_0000, 8'h00, 4'd3));
      pending_req.push_back(make_req(OP_READ,        32'h0000_0000, 8'h00, 4'd4));
      pending_req.push_back(make_req(OP_REMOVE_CODE, 32'h0000_0000, 8'h00, 4'd0));
      pending_req.push_back(make_req(OP_REMOVE_DATA, 32'h0000_0000, 8'h00, 4'd0));
      pending_req.push_back(make_req(OP_REMOVE_DATA, 32'h0000_1234, 8'h01, 4'd0));
      pending_req.push_back(make_req(OP_READ,        32'h0000_0000, 8'h00, 4'd1));
      pending_req.push_back(make_req(OP_REMOVE_IDX,  32'h0000_0000, 8'h00, 4'd0));
      pending_req.push_back(make_req(4'd9,           32'hFFFF_FFFF, 8'hFF, 4'd15));
      pending_req.push_back(make_req(4'd15,          32'h0000_0000, 8'h00, 4'd0));
      pending_req.push_back(make_req(OP_CLEAR,       32'hFFFF_FFFF, 8'hFF, 4'd15));
      pending_req.push_back(make_req(OP_ADD_CODE,    32'hA5A5_A5A5, 8'hFF, 4'd0));
      pending_req.push_back(make_req(OP_READ,        32'h0000_0000, 8'h00, 4'd0));

      // random phases over small address pools so the table fills and hits
      made = 0;
      while (made < RANDOM_ITEMS) begin
         pool_n  = $urandom_range(2, 24);
         phase_n = $urandom_range(60, 140);
         for (int i = 0; i < pool_n; i++) begin
            pick = $urandom_range(0, 9);
            addr_pool[i] = (pick == 0) ? 32'h0000_0000 :
                           (pick == 1) ? 32'hFFFF_FFFF : 32'($urandom());
         end
         for (int i = 0; i < 3; i++) len_pool[i] = 8'($urandom_range(0, 255));
         if ($urandom_range(0, 1) == 0) begin
            pending_req.push_back(make_req(OP_CLEAR, 32'($urandom()), 8'($urandom_range(0, 255)),
                                           4'($urandom_range(0, 15))));
            made++;
         end
         for (int k = 0; k < phase_n; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 22)      op = OP_ADD_CODE;
            else if (pick < 40) op = OP_ADD_DATA;
            else if (pick < 52) op = OP_FIND_CODE;
            else if (pick < 64) op = OP_FIND_DATA;
            else if (pick < 71) op = OP_REMOVE_CODE;
            else if (pick < 78) op = OP_REMOVE_DATA;
            else if (pick < 84) op = OP_REMOVE_IDX;
            else if (pick < 92) op = OP_READ;
            else if (pick < 94) op = OP_CLEAR;
            else                op = 4'($urandom_range(9, 15));
            if ($urandom_range(0, 99) < 85) a = addr_pool[$urandom_range(0, pool_n - 1)];
            else a = 32'($urandom());
            if ($urandom_range(0, 99) < 80) l = len_pool[$urandom_range(0, 2)];
            else l = 8'($urandom_range(0, 255));
            pending_req.push_back(make_req(op, a, l, 4'($urandom_range(0, 15))));
            made++;
         end
      end
      calm_mark = (pending_req.size() * 85) / 100;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (pending_req.size() > 0 || req_tvalid) @(posedge clock);
      while (due_rsp.size() > 0) @(posedge clock);
      repeat (8) @(posedge clock);

      if (mismatches == 0 && due_rsp.size() == 0) begin
         $display("breakpoint_match_table regression: pass");
      end else begin
         $display("breakpoint_match_table regression: fail");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/core/bmt_pkg.sv
rtl/core/bmt_cell.sv
rtl/core/breakpoint_match_table.sv
tb/tb.sv
